// ===== rtl/tbgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbgd_pkg
// Shared types and constants of the two-button gesture decoder.
// ----------------------------------------------------------------------------
package tbgd_pkg;

   localparam int TimeWidth     = 32;
   localparam int DebounceWidth = 10;
   localparam int IntervalWidth = 10;
   localparam int HoldWidth     = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   typedef logic [TimeWidth-1:0]     time_ms_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [CsrDataWidth-1:0]  csr_data_type;

   localparam csr_index_type CSR_DEBOUNCE_MS      = 2'd0;
   localparam csr_index_type CSR_POLL_INTERVAL_MS = 2'd1;
   localparam csr_index_type CSR_SAVE_HOLD_MS     = 2'd2;

   localparam logic [DebounceWidth-1:0] DEBOUNCE_RESET  = 10'd20;
   localparam logic [IntervalWidth-1:0] INTERVAL_RESET  = 10'd5;
   localparam logic [HoldWidth-1:0]     SAVE_HOLD_RESET = 16'd2000;

   // one poll as held in the input stage
   typedef struct packed {
      time_ms_type now_ms;
      logic        raw_startstop;
      logic        raw_shift;
      logic        any_knob_moved;
      logic        seq_running;
   } poll_type;

endpackage

// ===== rtl/two_button_gesture_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_gesture_decoder_unit
// Debounces start/stop and shift buttons per poll and decodes transport,
// save and pause gestures.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req_    | in        | req_valid / req_stall  | now_ms, raw levels, knob, running
//  rsp_    | out       | rsp_valid / rsp_stall  | poll_taken, requests, stable levels
//  csr_    | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
//  One poll per cycle while req_stall is low; the poll sits in the input register,
//  then the decode of it loads the result register.
//  The decode state updates as the result register loads a taken poll, so the
//  next poll sees it at once.
//  Reset is synchronous and active high; it restores register defaults.
//  rsp_stall holds the result register and backs up into req_stall.
// ----------------------------------------------------------------------------
module two_button_gesture_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tbgd_pkg::time_ms_type  req_now_ms,
   input  logic                   req_raw_startstop,
   input  logic                   req_raw_shift,
   input  logic                   req_any_knob_moved,
   input  logic                   req_seq_running,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_poll_taken,
   output logic                   rsp_toggle_transport,
   output logic                   rsp_stop_request,
   output logic                   rsp_save_request,
   output logic                   rsp_pause_toggle,
   output logic                   rsp_startstop_stable,
   output logic                   rsp_shift_stable,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tbgd_pkg::csr_index_type csr_index,
   input  tbgd_pkg::csr_data_type  csr_wdata
);
   import tbgd_pkg::*;

   // configuration
   logic [DebounceWidth-1:0] debounce_ff;
   logic [IntervalWidth-1:0] interval_ff;
   logic [HoldWidth-1:0]     hold_ff;

   // input stage
   logic     in_valid_ff;
   poll_type in_poll_ff;
   logic     in_load;

   // result stage
   logic out_valid_ff;
   logic out_load;
   logic taken_ff, toggle_ff, stop_ff, save_ff, pause_ff, ss_out_ff, sh_out_ff;

   // decode state
   logic        ss_level_ff, ss_raw_prev_ff, sh_level_ff, sh_raw_prev_ff;
   time_ms_type ss_raw_time_ff, sh_raw_time_ff, last_poll_ff, combo_time_ff;
   logic        combo_on_ff, combo_done_ff, combo_used_ff;

   logic        ss_level_in, ss_raw_prev_in, sh_level_in, sh_raw_prev_in;
   time_ms_type ss_raw_time_in, sh_raw_time_in, last_poll_in, combo_time_in;
   logic        combo_on_in, combo_done_in, combo_used_in;
   logic        taken_in, toggle_in, stop_in, save_in, pause_in;

   time_ms_type poll_gap, ss_gap, sh_gap, combo_gap;
   logic        ss_changed, sh_changed, start_combo, press, save_fire, release_combo;
   logic        on_eff, done_eff, used_eff, done_after_save;
   time_ms_type combo_time_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         interval_ff <= INTERVAL_RESET;
         hold_ff     <= SAVE_HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:      debounce_ff <= csr_wdata[DebounceWidth-1:0];
            CSR_POLL_INTERVAL_MS: interval_ff <= csr_wdata[IntervalWidth-1:0];
            CSR_SAVE_HOLD_MS:     hold_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: result register loads when empty or drained
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (out_load) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_poll_ff <= '{now_ms: req_now_ms, raw_startstop: req_raw_startstop,
                         raw_shift: req_raw_shift, any_knob_moved: req_any_knob_moved,
                         seq_running: req_seq_running};
      end
   end

   // decode one poll
   always_comb begin
      poll_gap  = in_poll_ff.now_ms - last_poll_ff;
      ss_gap    = in_poll_ff.now_ms - ss_raw_time_ff;
      sh_gap    = in_poll_ff.now_ms - sh_raw_time_ff;
      taken_in  = poll_gap >= TimeWidth'(interval_ff);

      // debounce: restart the timer on a raw edge, else adopt after the hold
      ss_changed     = in_poll_ff.raw_startstop != ss_raw_prev_ff;
      sh_changed     = in_poll_ff.raw_shift != sh_raw_prev_ff;
      ss_raw_prev_in = in_poll_ff.raw_startstop;
      sh_raw_prev_in = in_poll_ff.raw_shift;
      ss_raw_time_in = ss_changed ? in_poll_ff.now_ms : ss_raw_time_ff;
      sh_raw_time_in = sh_changed ? in_poll_ff.now_ms : sh_raw_time_ff;
      ss_level_in    = ss_level_ff;
      sh_level_in    = sh_level_ff;
      if (!ss_changed && ss_gap >= TimeWidth'(debounce_ff)) begin
         ss_level_in = in_poll_ff.raw_startstop;
      end
      if (!sh_changed && sh_gap >= TimeWidth'(debounce_ff)) begin
         sh_level_in = in_poll_ff.raw_shift;
      end

      press          = ss_level_in && !ss_level_ff;
      start_combo    = press && sh_level_in;
      toggle_in      = press && !sh_level_in;
      on_eff         = combo_on_ff || start_combo;
      done_eff       = combo_done_ff && !start_combo;
      used_eff       = combo_used_ff && !start_combo;
      combo_time_eff = start_combo ? in_poll_ff.now_ms : combo_time_ff;
      combo_gap      = in_poll_ff.now_ms - combo_time_eff;

      save_fire       = on_eff && !done_eff && !used_eff &&
                        combo_gap >= TimeWidth'(hold_ff);
      save_in         = save_fire;
      stop_in         = save_fire && in_poll_ff.seq_running;
      done_after_save = done_eff || save_fire;

      release_combo = on_eff && (!ss_level_in || !sh_level_in);
      pause_in      = release_combo && !done_after_save && !used_eff;

      combo_on_in   = on_eff && !release_combo;
      combo_done_in = done_after_save && !release_combo;
      combo_used_in = (used_eff && !release_combo) ||
                      (sh_level_in && in_poll_ff.any_knob_moved);
      combo_time_in = combo_time_eff;
      last_poll_in  = in_poll_ff.now_ms;
   end

   // state advances only on a taken poll leaving the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ss_level_ff    <= 1'b0;
         ss_raw_prev_ff <= 1'b0;
         ss_raw_time_ff <= '0;
         sh_level_ff    <= 1'b0;
         sh_raw_prev_ff <= 1'b0;
         sh_raw_time_ff <= '0;
         last_poll_ff   <= '0;
         combo_on_ff    <= 1'b0;
         combo_time_ff  <= '0;
         combo_done_ff  <= 1'b0;
         combo_used_ff  <= 1'b0;
      end else if (in_valid_ff && out_load && taken_in) begin
         ss_level_ff    <= ss_level_in;
         ss_raw_prev_ff <= ss_raw_prev_in;
         ss_raw_time_ff <= ss_raw_time_in;
         sh_level_ff    <= sh_level_in;
         sh_raw_prev_ff <= sh_raw_prev_in;
         sh_raw_time_ff <= sh_raw_time_in;
         last_poll_ff   <= last_poll_in;
         combo_on_ff    <= combo_on_in;
         combo_time_ff  <= combo_time_in;
         combo_done_ff  <= combo_done_in;
         combo_used_ff  <= combo_used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && out_load) begin
         taken_ff  <= taken_in;
         toggle_ff <= taken_in && toggle_in;
         stop_ff   <= taken_in && stop_in;
         save_ff   <= taken_in && save_in;
         pause_ff  <= taken_in && pause_in;
         ss_out_ff <= taken_in ? ss_level_in : ss_level_ff;
         sh_out_ff <= taken_in ? sh_level_in : sh_level_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_poll_taken       = taken_ff;
   assign rsp_toggle_transport = toggle_ff;
   assign rsp_stop_request     = stop_ff;
   assign rsp_save_request     = save_ff;
   assign rsp_pause_toggle     = pause_ff;
   assign rsp_startstop_stable = ss_out_ff;
   assign rsp_shift_stable     = sh_out_ff;

endmodule

// ===== rtl/tbgd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbgd_checker
// Port-level checks of the gesture decoder results, bound to the top level.
// ----------------------------------------------------------------------------
module tbgd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_poll_taken,
   input logic rsp_toggle_transport,
   input logic rsp_stop_request,
   input logic rsp_save_request,
   input logic rsp_pause_toggle,
   input logic rsp_startstop_stable,
   input logic rsp_shift_stable
);

   // an ignored poll carries no requests
   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_poll_taken) |->
         !(rsp_toggle_transport || rsp_stop_request || rsp_save_request ||
           rsp_pause_toggle))
      else $error("requests on an ignored poll");

   // a stop is only ever issued together with a save
   a_stop_with_save: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_request) |-> rsp_save_request)
      else $error("stop without save");

   // a transport toggle comes from a plain press without shift
   a_toggle_levels: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_toggle_transport) |->
         (rsp_startstop_stable && !rsp_shift_stable && !rsp_pause_toggle))
      else $error("toggle with inconsistent levels");

   // a pause on release excludes a save in the same beat
   a_pause_no_save: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pause_toggle) |->
         (!rsp_save_request && !(rsp_startstop_stable && rsp_shift_stable)))
      else $error("pause with save or with both buttons held");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind two_button_gesture_decoder_unit tbgd_checker u_tbgd_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_poll_taken       (rsp_poll_taken),
   .rsp_toggle_transport (rsp_toggle_transport),
   .rsp_stop_request     (rsp_stop_request),
   .rsp_save_request     (rsp_save_request),
   .rsp_pause_toggle     (rsp_pause_toggle),
   .rsp_startstop_stable (rsp_startstop_stable),
   .rsp_shift_stable     (rsp_shift_stable)
);

// ===== tb/sv/gesture_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_checker
// Watches the poll, result and register channels of the gesture decoder,
// keeps its own model of the debounce and combo state, and compares every
// result beat field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module gesture_checker
   import tbgd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  time_ms_type   req_now_ms,
   input  logic          req_raw_startstop,
   input  logic          req_raw_shift,
   input  logic          req_any_knob_moved,
   input  logic          req_seq_running,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic          rsp_poll_taken,
   input  logic          rsp_toggle_transport,
   input  logic          rsp_stop_request,
   input  logic          rsp_save_request,
   input  logic          rsp_pause_toggle,
   input  logic          rsp_startstop_stable,
   input  logic          rsp_shift_stable,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata,
   output int            fail_count,
   output int            pending
);

   typedef struct packed {
      logic poll_taken;
      logic toggle_transport;
      logic stop_request;
      logic save_request;
      logic pause_toggle;
      logic startstop_stable;
      logic shift_stable;
   } gesture_result_type;

   // register copies
   logic [DebounceWidth-1:0] debounce_cfg;
   logic [IntervalWidth-1:0] interval_cfg;
   logic [HoldWidth-1:0]     hold_cfg;

   // decode state
   logic        ss_level, ss_prev, sh_level, sh_prev;
   time_ms_type ss_since, sh_since, last_poll, combo_start;
   logic        combo_on, combo_done, combo_used;

   gesture_result_type expected_results[$];
   gesture_result_type got, want;
   poll_type           poll;
   string              fname;
   int                 results_seen;
   int                 k;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
   end

   task automatic flag_mismatch(input string what);
      fail_count++;
      $display("mismatch: %s", what);
   endtask

   // returns {level, prev, since}
   function automatic logic [33:0] debounce_step(input logic raw, input time_ms_type now,
                                                 input logic level, input logic prev,
                                                 input time_ms_type since);
      time_ms_type held;
      held = now - since;
      if (raw != prev) debounce_step = {level, raw, now};
      else if (raw != level && held >= debounce_cfg) debounce_step = {raw, prev, since};
      else debounce_step = {level, prev, since};
   endfunction

   function automatic gesture_result_type decode_poll(input poll_type p);
      gesture_result_type r;
      time_ms_type        elapsed;
      time_ms_type        combo_age;
      logic               ss_was;
      r = '0;
      elapsed = p.now_ms - last_poll;
      if (elapsed < interval_cfg) begin
         // too soon: drop the poll, report the held levels
         r.startstop_stable = ss_level;
         r.shift_stable     = sh_level;
      end else begin
         last_poll = p.now_ms;
         ss_was = ss_level;
         {ss_level, ss_prev, ss_since} =
            debounce_step(p.raw_startstop, p.now_ms, ss_level, ss_prev, ss_since);
         {sh_level, sh_prev, sh_since} =
            debounce_step(p.raw_shift, p.now_ms, sh_level, sh_prev, sh_since);
         if (ss_level && !ss_was) begin
            if (sh_level) begin
               combo_on    = 1'b1;
               combo_start = p.now_ms;
               combo_done  = 1'b0;
               combo_used  = 1'b0;
            end else begin
               r.toggle_transport = 1'b1;
            end
         end
         combo_age = p.now_ms - combo_start;
         if (combo_on && !combo_done && !combo_used && combo_age >= hold_cfg) begin
            r.stop_request = p.seq_running;
            r.save_request = 1'b1;
            combo_done     = 1'b1;
         end
         // release sees the save of this same poll
         if (combo_on && (!ss_level || !sh_level)) begin
            if (!combo_done && !combo_used) r.pause_toggle = 1'b1;
            combo_on   = 1'b0;
            combo_done = 1'b0;
            combo_used = 1'b0;
         end
         if (sh_level && p.any_knob_moved) combo_used = 1'b1;
         r.poll_taken       = 1'b1;
         r.startstop_stable = ss_level;
         r.shift_stable     = sh_level;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         debounce_cfg = DEBOUNCE_RESET;
         interval_cfg = INTERVAL_RESET;
         hold_cfg     = SAVE_HOLD_RESET;
         ss_level = 1'b0; ss_prev = 1'b0; ss_since = '0;
         sh_level = 1'b0; sh_prev = 1'b0; sh_since = '0;
         last_poll   = '0;
         combo_on    = 1'b0;
         combo_start = '0;
         combo_done  = 1'b0;
         combo_used  = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE_MS:      debounce_cfg = csr_wdata[DebounceWidth-1:0];
               CSR_POLL_INTERVAL_MS: interval_cfg = csr_wdata[IntervalWidth-1:0];
               CSR_SAVE_HOLD_MS:     hold_cfg     = csr_wdata[HoldWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_poll_taken, rsp_toggle_transport, rsp_stop_request, rsp_save_request,
                   rsp_pause_toggle, rsp_startstop_stable, rsp_shift_stable};
            if (expected_results.size() == 0) begin
               flag_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                       results_seen));
            end else begin
               want = expected_results.pop_front();
               for (k = 6; k >= 0; k--) begin
                  if (got[k] !== want[k]) begin
                     case (k)
                        6:       fname = "poll_taken";
                        5:       fname = "toggle_transport";
                        4:       fname = "stop_request";
                        3:       fname = "save_request";
                        2:       fname = "pause_toggle";
                        1:       fname = "startstop_stable";
                        default: fname = "shift_stable";
                     endcase
                     flag_mismatch($sformatf("result beat %0d %s expected %b got %b",
                                             results_seen, fname, want[k], got[k]));
                  end
               end
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            poll = {req_now_ms, req_raw_startstop, req_raw_shift, req_any_knob_moved,
                    req_seq_running};
            expected_results.push_back(decode_poll(poll));
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives button polls and register writes into the gesture decoder: a short
// directed sequence, then random taps, shift combos, knob use and noise over
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import tbgd_pkg::*;

   localparam csr_index_type CSR_UNUSED = 2'd3;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   time_ms_type   req_now_ms;
   logic          req_raw_startstop;
   logic          req_raw_shift;
   logic          req_any_knob_moved;
   logic          req_seq_running;
   logic          rsp_valid;
   logic          rsp_stall;
   logic          rsp_poll_taken;
   logic          rsp_toggle_transport;
   logic          rsp_stop_request;
   logic          rsp_save_request;
   logic          rsp_pause_toggle;
   logic          rsp_startstop_stable;
   logic          rsp_shift_stable;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;
   int            fail_count;
   int            pending;

   time_ms_type stamp_ms      = '0;
   logic        running_level = 1'b0;
   logic        calm          = 1'b0;
   int          dbn_ms        = 20;
   int          gap_ms        = 5;
   int          hold_ms       = 2000;
   int          pace_ms       = 168;
   int          req_idle_pct  = 10;
   int          rsp_stall_pct = 10;
   int          polls_sent    = 0;
   int          phase;
   int          target;

   always #4 clock = ~clock;

   two_button_gesture_decoder_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_now_ms           (req_now_ms),
      .req_raw_startstop    (req_raw_startstop),
      .req_raw_shift        (req_raw_shift),
      .req_any_knob_moved   (req_any_knob_moved),
      .req_seq_running      (req_seq_running),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_poll_taken       (rsp_poll_taken),
      .rsp_toggle_transport (rsp_toggle_transport),
      .rsp_stop_request     (rsp_stop_request),
      .rsp_save_request     (rsp_save_request),
      .rsp_pause_toggle     (rsp_pause_toggle),
      .rsp_startstop_stable (rsp_startstop_stable),
      .rsp_shift_stable     (rsp_shift_stable),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   gesture_checker gesture_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_now_ms           (req_now_ms),
      .req_raw_startstop    (req_raw_startstop),
      .req_raw_shift        (req_raw_shift),
      .req_any_knob_moved   (req_any_knob_moved),
      .req_seq_running      (req_seq_running),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_poll_taken       (rsp_poll_taken),
      .rsp_toggle_transport (rsp_toggle_transport),
      .rsp_stop_request     (rsp_stop_request),
      .rsp_save_request     (rsp_save_request),
      .rsp_pause_toggle     (rsp_pause_toggle),
      .rsp_startstop_stable (rsp_startstop_stable),
      .rsp_shift_stable     (rsp_shift_stable),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .pending              (pending)
   );

   // result side back-pressure in bursts
   initial begin
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_poll(input time_ms_type now, input logic ss, input logic sh,
                            input logic knob, input logic run);
      if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_now_ms         <= now;
      req_raw_startstop  <= ss;
      req_raw_shift      <= sh;
      req_any_knob_moved <= knob;
      req_seq_running    <= run;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      polls_sent++;
   endtask

   // wait out every outstanding result, then the pipeline latency
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes never lower and raise it in one step
   task automatic write_csr(input csr_index_type idx, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input int dbn, input int gap, input int hold);
      csr_data_type w;
      drain();
      w = CsrDataWidth'(dbn);
      if ($urandom_range(0, 1)) w[15:10] = 6'($urandom_range(0, 63));
      write_csr(CSR_DEBOUNCE_MS, w);
      w = CsrDataWidth'(gap);
      if ($urandom_range(0, 1)) w[15:10] = 6'($urandom_range(0, 63));
      write_csr(CSR_POLL_INTERVAL_MS, w);
      write_csr(CSR_SAVE_HOLD_MS, CsrDataWidth'(hold));
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, CsrDataWidth'($urandom()));
      csr_valid <= 1'b0;
      dbn_ms  = dbn;
      gap_ms  = gap;
      hold_ms = hold;
      pace_ms = (dbn + hold) / 12;
      if (pace_ms < 1) pace_ms = 1;
   endtask

   function automatic int pick_step();
      int base;
      if (gap_ms > 0 && $urandom_range(0, 99) < 8) return $urandom_range(0, gap_ms - 1);
      base = (gap_ms > pace_ms / 2) ? gap_ms : pace_ms / 2;
      return base + $urandom_range(0, pace_ms);
   endfunction

   // hold the raw levels for about dur ms of poll time
   task automatic hold_levels(input logic ss, input logic sh, input int dur,
                              input int knob_pct);
      int elapsed;
      int step;
      elapsed = 0;
      do begin
         if ($urandom_range(0, 99) == 0) begin
            stamp_ms = $urandom();
            step     = pace_ms;
         end else begin
            step     = pick_step();
            stamp_ms = stamp_ms + step;
         end
         elapsed += step;
         send_poll(stamp_ms, ss, sh, $urandom_range(0, 99) < knob_pct, running_level);
      end while (elapsed < dur);
   endtask

   task automatic play_gesture();
      int kind;
      int dur;
      int jitter;
      int n;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) running_level = ~running_level;
      if (kind < 2) begin
         hold_levels(1'b1, 1'b0, dbn_ms + $urandom_range(0, 2 * pace_ms), 0);
         hold_levels(1'b0, 1'b0, dbn_ms + $urandom_range(pace_ms, 3 * pace_ms), 0);
      end else if (kind < 6) begin
         hold_levels(1'b0, 1'b1, dbn_ms + $urandom_range(pace_ms, 2 * pace_ms),
                     ($urandom_range(0, 4) == 0) ? 40 : 0);
         jitter = $urandom_range(0, 2 * pace_ms);
         case ($urandom_range(0, 2))
            0:       dur = hold_ms / 2;
            1:       dur = hold_ms + jitter + pace_ms;
            default: dur = hold_ms - pace_ms + jitter;
         endcase
         if (dur < 0) dur = 0;
         hold_levels(1'b1, 1'b1, dbn_ms + dur, ($urandom_range(0, 2) == 0) ? 15 : 0);
         case ($urandom_range(0, 2))
            0:       hold_levels(1'b0, 1'b1, dbn_ms + pace_ms, 0);
            1:       hold_levels(1'b1, 1'b0, dbn_ms + pace_ms, 0);
            default: ;
         endcase
         hold_levels(1'b0, 1'b0, dbn_ms + $urandom_range(pace_ms, 2 * pace_ms), 0);
      end else if (kind == 6) begin
         hold_levels(1'b0, 1'b1, dbn_ms + 3 * pace_ms, 50);
         hold_levels(1'b0, 1'b0, dbn_ms + pace_ms, 0);
      end else begin
         // bounce and junk levels
         n = $urandom_range(3, 12);
         repeat (n) begin
            running_level = 1'($urandom_range(0, 1));
            hold_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, dbn_ms + pace_ms), 30);
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_now_ms         <= '0;
      req_raw_startstop  <= 1'b0;
      req_raw_shift      <= 1'b0;
      req_any_knob_moved <= 1'b0;
      req_seq_running    <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= CSR_DEBOUNCE_MS;
      csr_wdata          <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: early polls dropped, combo with knob use, wrap of time
      send_poll(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_poll(32'd4, 1'b1, 1'b1, 1'b1, 1'b1);
      send_poll(32'd5, 1'b1, 1'b1, 1'b1, 1'b1);
      send_poll(32'd25, 1'b1, 1'b1, 1'b0, 1'b1);
      send_poll(32'd30, 1'b1, 1'b1, 1'b1, 1'b1);
      send_poll(32'd40, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd60, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd80, 1'b0, 1'b0, 1'b0, 1'b0);
      send_poll(32'd100, 1'b0, 1'b0, 1'b0, 1'b0);
      send_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_poll(32'h0000_0013, 1'b1, 1'b0, 1'b0, 1'b0);
      send_poll(32'h0000_0017, 1'b0, 1'b0, 1'b1, 1'b1);

      // zero hold: the combo saves in the poll that starts it
      set_config(0, 0, 0);
      send_poll(32'd200, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd200, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd201, 1'b1, 1'b1, 1'b0, 1'b1);
      send_poll(32'd201, 1'b1, 1'b1, 1'b0, 1'b1);
      send_poll(32'd202, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd203, 1'b0, 1'b1, 1'b0, 1'b1);

      // save and release in one poll, then a plain release that pauses
      set_config(0, 0, 10);
      send_poll(32'd300, 1'b1, 1'b1, 1'b0, 1'b0);
      send_poll(32'd300, 1'b1, 1'b1, 1'b0, 1'b0);
      send_poll(32'd305, 1'b1, 1'b0, 1'b0, 1'b0);
      send_poll(32'd312, 1'b1, 1'b0, 1'b0, 1'b0);
      send_poll(32'd330, 1'b0, 1'b1, 1'b0, 1'b0);
      send_poll(32'd331, 1'b0, 1'b1, 1'b0, 1'b0);
      send_poll(32'd332, 1'b1, 1'b1, 1'b0, 1'b0);
      send_poll(32'd333, 1'b1, 1'b1, 1'b0, 1'b0);
      send_poll(32'd334, 1'b0, 1'b1, 1'b0, 1'b0);
      send_poll(32'd335, 1'b0, 1'b1, 1'b0, 1'b0);
      stamp_ms = 32'd400;

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_config(0, 0, 0);
            1: set_config(1000, 1000, 65535);
            2: set_config($urandom_range(0, 1000), $urandom_range(0, 1000),
                          $urandom_range(0, 65535));
            default: set_config($urandom_range(0, 40), $urandom_range(0, 10),
                                $urandom_range(0, 300));
         endcase
         calm = (phase == 7);
         case ($urandom_range(0, 2))
            0:       req_idle_pct = 0;
            1:       req_idle_pct = 10;
            default: req_idle_pct = 35;
         endcase
         case ($urandom_range(0, 2))
            0:       rsp_stall_pct = 0;
            1:       rsp_stall_pct = 8;
            default: rsp_stall_pct = 25;
         endcase
         if (phase == 4) stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
         target = polls_sent + 100;
         while (polls_sent < target) play_gesture();
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
